// ===== rtl/core/vpa_pkg.sv =====
package vpa_pkg;

  // Request opcodes
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Result codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_FIT   = 3'd2;
  localparam logic [2:0] ST_NO_OWNER = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Placement policies; the unused code behaves as first fit
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Register index of fit_policy
  localparam logic REG_FIT_POLICY = 1'b0;

  localparam int SIZE_W = 9;
  localparam int ADDR_W = 9;
  localparam int OWNER_W = 8;

  typedef struct packed {
    logic               func;
    logic [OWNER_W-1:0] owner_id;
    logic [SIZE_W-1:0]  request_size;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] user_address;
  } res_t;

endpackage

// ===== rtl/core/variable_partition_allocator.sv =====
// A rejected zero-size allocate answers in the cycle after start; every other request
//   walks the partition table in up to three passes (scan, shift on split, merge).
// Throughput: one request at a time; busy stays high until the result strobe.
// The result is shown for one cycle on done; the receiver cannot stall.
// Reset: one free partition covers the memory, fit_policy is first fit, no clearing pass.
module variable_partition_allocator #(
  parameter int MEM_WORDS = 512,
  parameter int MAX_PARTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  vpa_pkg::req_t        req,
  output logic                 done,
  output vpa_pkg::res_t        result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int SW = $clog2(MEM_WORDS);
  localparam int LW = SW + 1;
  localparam int NW = vpa_pkg::SIZE_W + 1;
  localparam int CW = (LW > NW) ? LW : NW;
  localparam int IW = $clog2(MAX_PARTS);
  localparam int CNTW = $clog2(MAX_PARTS + 1);
  localparam int EW = SW + LW + 1 + vpa_pkg::OWNER_W;

  typedef struct packed {
    logic [SW-1:0]               start;
    logic [LW-1:0]               len;
    logic                        free;
    logic [vpa_pkg::OWNER_W-1:0] owner;
  } entry_t;

  localparam entry_t ENTRY0 = '{start: '0, len: LW'(MEM_WORDS), free: 1'b1, owner: '0};

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_SHIFT_RD, S_SHIFT_WR,
    S_WR_NEW, S_WR_PICK, S_MRG_RD, S_MRG_EV, S_MRG_FLUSH
  } state_t;

  state_t             state;
  vpa_pkg::req_t      cur;
  logic [1:0]         fit_policy;
  logic [CNTW-1:0]    count;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      pick;
  logic [IW-1:0]      wr_idx;
  logic [CW-1:0]      best;
  logic               found;
  logic               hit;
  entry_t             pick_e;
  entry_t             acc;
  logic               acc_v;

  logic [IW-1:0]      raddr;
  logic [EW-1:0]      rdata_raw;
  entry_t             rd;
  logic               we;
  logic [IW-1:0]      waddr;
  entry_t             wdata;

  logic [CW-1:0]      need;
  logic [CW-1:0]      rd_len;
  logic [CW-1:0]      diff;
  logic               fits;
  logic               better;
  logic               first_mode;
  logic               last_idx;

  vpa_table #(
    .DEPTH(MAX_PARTS),
    .EW(EW),
    .ENTRY0_RESET(ENTRY0)
  ) u_table (
    .clk(clk),
    .rst(rst),
    .raddr(raddr),
    .rdata(rdata_raw),
    .we(we),
    .waddr(waddr),
    .wdata(wdata)
  );

  assign rd = entry_t'(rdata_raw);

  // Shared compare/subtract unit used by the scan
  assign need = CW'(cur.request_size) + CW'(1);
  assign rd_len = CW'(rd.len);
  assign fits = rd.free && (rd_len >= need);
  assign diff = rd_len - need;
  assign first_mode = (fit_policy != vpa_pkg::POL_BEST) && (fit_policy != vpa_pkg::POL_WORST);
  assign better = !found ||
                  ((fit_policy == vpa_pkg::POL_BEST) && (diff < best)) ||
                  ((fit_policy == vpa_pkg::POL_WORST) && (diff > best));
  assign last_idx = (CNTW'(idx) + CNTW'(1)) == count;

  assign busy = (state != S_IDLE);

  // Table port selection per state
  always_comb begin
    raddr = idx;
    we = 1'b0;
    waddr = idx;
    wdata = rd;
    case (state)
      S_SCAN_EV: begin
        if (cur.func == vpa_pkg::FUNC_RELEASE && !rd.free && rd.owner == cur.owner_id) begin
          we = 1'b1;
          wdata = '{start: rd.start, len: rd.len, free: 1'b1, owner: '0};
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = idx + IW'(1);
        wdata = rd;
      end
      S_WR_NEW: begin
        we = 1'b1;
        waddr = pick + IW'(1);
        wdata = '{start: pick_e.start + SW'(need), len: LW'(best), free: 1'b1, owner: '0};
      end
      S_WR_PICK: begin
        we = 1'b1;
        waddr = pick;
        wdata = '{start: pick_e.start, len: LW'(need), free: 1'b0, owner: cur.owner_id};
      end
      S_MRG_EV: begin
        we = acc_v && !(acc.free && rd.free);
        waddr = wr_idx;
        wdata = acc;
      end
      S_MRG_FLUSH: begin
        we = 1'b1;
        waddr = wr_idx;
        wdata = acc;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CNTW'(1);
      done <= 1'b0;
      result <= '0;
      idx <= '0;
      found <= 1'b0;
      hit <= 1'b0;
      acc_v <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            idx <= '0;
            found <= 1'b0;
            hit <= 1'b0;
            best <= '0;
            if (req.func == vpa_pkg::FUNC_ALLOC && req.request_size == '0) begin
              done <= 1'b1;
              result <= '{status: vpa_pkg::ST_BAD_SIZE, user_address: '0};
            end else begin
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          if (cur.func == vpa_pkg::FUNC_RELEASE) begin
            if (!rd.free && rd.owner == cur.owner_id) begin
              hit <= 1'b1;
            end
            if (last_idx) begin
              if (hit || (!rd.free && rd.owner == cur.owner_id)) begin
                idx <= '0;
                wr_idx <= '0;
                acc_v <= 1'b0;
                state <= S_MRG_RD;
              end else begin
                done <= 1'b1;
                result <= '{status: vpa_pkg::ST_NO_OWNER, user_address: '0};
                state <= S_IDLE;
              end
            end else begin
              idx <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end else begin
            if (fits && better) begin
              found <= 1'b1;
              pick <= idx;
              best <= diff;
              pick_e <= rd;
            end
            if (last_idx || (fits && first_mode)) begin
              if (found || fits) begin
                state <= S_DECIDE;
              end else begin
                done <= 1'b1;
                result <= '{status: vpa_pkg::ST_NO_FIT, user_address: '0};
                state <= S_IDLE;
              end
            end else begin
              idx <= idx + IW'(1);
              state <= S_SCAN_RD;
            end
          end
        end
        S_DECIDE: begin
          if (best == '0) begin
            state <= S_WR_PICK;
          end else if (count == CNTW'(MAX_PARTS)) begin
            done <= 1'b1;
            result <= '{status: vpa_pkg::ST_FULL, user_address: '0};
            state <= S_IDLE;
          end else if (count > CNTW'(pick) + CNTW'(1)) begin
            idx <= IW'(count - CNTW'(1));
            state <= S_SHIFT_RD;
          end else begin
            state <= S_WR_NEW;
          end
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (idx == pick + IW'(1)) begin
            state <= S_WR_NEW;
          end else begin
            idx <= idx - IW'(1);
            state <= S_SHIFT_RD;
          end
        end
        S_WR_NEW: begin
          count <= count + CNTW'(1);
          state <= S_WR_PICK;
        end
        S_WR_PICK: begin
          idx <= '0;
          wr_idx <= '0;
          acc_v <= 1'b0;
          state <= S_MRG_RD;
        end
        S_MRG_RD: begin
          state <= S_MRG_EV;
        end
        S_MRG_EV: begin
          if (acc_v && acc.free && rd.free) begin
            acc.len <= acc.len + rd.len;
          end else begin
            if (acc_v) begin
              wr_idx <= wr_idx + IW'(1);
            end
            acc <= rd;
            acc_v <= 1'b1;
          end
          if (last_idx) begin
            state <= S_MRG_FLUSH;
          end else begin
            idx <= idx + IW'(1);
            state <= S_MRG_RD;
          end
        end
        S_MRG_FLUSH: begin
          count <= CNTW'(wr_idx) + CNTW'(1);
          done <= 1'b1;
          if (cur.func == vpa_pkg::FUNC_ALLOC) begin
            result <= '{status: vpa_pkg::ST_OK,
                        user_address: vpa_pkg::ADDR_W'(CW'(pick_e.start) + CW'(1))};
          end else begin
            result <= '{status: vpa_pkg::ST_OK, user_address: '0};
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= vpa_pkg::POL_FIRST;
    end else if (psel && penable && pwrite && paddr[2] == vpa_pkg::REG_FIT_POLICY) begin
      fit_policy <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vpa_pkg::REG_FIT_POLICY) ? {30'd0, fit_policy} : 32'd0;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNTW'(MAX_PARTS)))
    else $error("partition count out of range");
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != vpa_pkg::ST_OK) |-> (result.user_address == '0))
    else $error("address on failed request");
  a_bad_size_fast: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.func == vpa_pkg::FUNC_ALLOC && req.request_size == '0)
    |=> (done && result.status == vpa_pkg::ST_BAD_SIZE))
    else $error("zero size not rejected");
`endif

endmodule

// ===== rtl/core/vpa_table.sv =====
module vpa_table #(
  parameter int DEPTH = 64,
  parameter int EW = 28,
  parameter logic [EW-1:0] ENTRY0_RESET = '0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [EW-1:0]            rdata,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [EW-1:0]            wdata
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_mem;
  logic          init0;
  logic          rd_init;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem <= mem[raddr];
  end

  // Entry 0 reads as its reset value until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      init0   <= 1'b1;
      rd_init <= 1'b0;
    end else begin
      rd_init <= init0 && (raddr == '0);
      if (we && (waddr == '0)) begin
        init0 <= 1'b0;
      end
    end
  end

  assign rdata = rd_init ? ENTRY0_RESET : rd_mem;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MEM_WORDS = 512;
  localparam int MAX_PARTS = 64;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  vpa_pkg::req_t req = '0;
  logic done;
  vpa_pkg::res_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  variable_partition_allocator #(.MEM_WORDS(MEM_WORDS), .MAX_PARTS(MAX_PARTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .done(done),
    .result(result), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow copy of the partition table
  logic [9:0] pt_start [MAX_PARTS];
  logic [10:0] pt_len [MAX_PARTS];
  logic pt_free [MAX_PARTS];
  logic [7:0] pt_owner [MAX_PARTS];
  int pt_count;
  logic [1:0] policy;

  vpa_pkg::res_t pending_results[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int idle_cycles = 0;
  int status_seen [5];

  function automatic void table_reset();
    for (int i = 0; i < MAX_PARTS; i++) begin
      pt_start[i] = '0;
      pt_len[i] = '0;
      pt_free[i] = 1'b0;
      pt_owner[i] = '0;
    end
    pt_len[0] = 11'(MEM_WORDS);
    pt_free[0] = 1'b1;
    pt_count = 1;
  endfunction

  function automatic void merge_runs();
    int w;
    w = 0;
    for (int r = 0; r < pt_count; r++) begin
      if (w > 0 && pt_free[w-1] && pt_free[r]) begin
        pt_len[w-1] += pt_len[r];
      end else begin
        pt_start[w] = pt_start[r];
        pt_len[w] = pt_len[r];
        pt_free[w] = pt_free[r];
        pt_owner[w] = pt_owner[r];
        w++;
      end
    end
    pt_count = w;
  endfunction

  // Compute the answer for one request and update the shadow table
  function automatic vpa_pkg::res_t allocate_or_release(vpa_pkg::req_t r);
    vpa_pkg::res_t o;
    int need, pick, best, diff, left;
    bit found;
    o = '0;
    found = 0;
    pick = 0;
    best = 0;
    if (r.func == vpa_pkg::FUNC_RELEASE) begin
      for (int i = 0; i < pt_count; i++) begin
        if (!pt_free[i] && pt_owner[i] == r.owner_id) begin
          pt_free[i] = 1'b1;
          pt_owner[i] = '0;
          found = 1;
        end
      end
      if (!found) begin
        o.status = vpa_pkg::ST_NO_OWNER;
      end else begin
        merge_runs();
        o.status = vpa_pkg::ST_OK;
      end
      return o;
    end
    if (r.request_size == 0) begin
      o.status = vpa_pkg::ST_BAD_SIZE;
      return o;
    end
    need = r.request_size + 1;
    for (int i = 0; i < pt_count; i++) begin
      if (!pt_free[i] || pt_len[i] < need) continue;
      diff = pt_len[i] - need;
      if (!found) begin
        found = 1;
        pick = i;
        best = diff;
        if (policy != vpa_pkg::POL_BEST && policy != vpa_pkg::POL_WORST) break;
      end else if (policy == vpa_pkg::POL_BEST && diff < best) begin
        pick = i;
        best = diff;
      end else if (policy == vpa_pkg::POL_WORST && diff > best) begin
        pick = i;
        best = diff;
      end
    end
    if (!found) begin
      o.status = vpa_pkg::ST_NO_FIT;
      return o;
    end
    left = pt_len[pick] - need;
    if (left > 0) begin
      if (pt_count >= MAX_PARTS) begin
        o.status = vpa_pkg::ST_FULL;
        return o;
      end
      for (int i = pt_count; i > pick + 1; i--) begin
        pt_start[i] = pt_start[i-1];
        pt_len[i] = pt_len[i-1];
        pt_free[i] = pt_free[i-1];
        pt_owner[i] = pt_owner[i-1];
      end
      pt_start[pick+1] = 10'(pt_start[pick] + need);
      pt_len[pick+1] = 11'(left);
      pt_free[pick+1] = 1'b1;
      pt_owner[pick+1] = '0;
      pt_count++;
    end
    pt_free[pick] = 1'b0;
    pt_owner[pick] = r.owner_id;
    pt_len[pick] = 11'(need);
    o.status = vpa_pkg::ST_OK;
    o.user_address = 9'(pt_start[pick] + 1);
    merge_runs();
    return o;
  endfunction

  // Pick a random sender gap, mostly short
  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // Issue one request and record its expected answer; start stays high after the transfer
  task automatic send_request(logic func, logic [7:0] owner, logic [8:0] size);
    vpa_pkg::req_t r;
    int n;
    r.func = func;
    r.owner_id = owner;
    r.request_size = size;
    n = gap_len();
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(allocate_or_release(r));
    sent++;
  endtask

  // Drop start and hold until every expected result has come
  task automatic wait_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (8 * MAX_PARTS) @(posedge clk);
  endtask

  // Write the policy register while idle
  task automatic write_policy(logic [1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * vpa_pkg::REG_FIT_POLICY);
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    policy = value;
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result status=%0d address=%0d", result.status, result.user_address);
        errors++;
      end else begin
        vpa_pkg::res_t e;
        e = pending_results.pop_front();
        if (result.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, result.status);
          errors++;
        end
        if (result.user_address !== e.user_address) begin
          $error("user_address expected %0d actual %0d", e.user_address, result.user_address);
          errors++;
        end
        if (e.status <= vpa_pkg::ST_FULL) status_seen[e.status]++;
        checked++;
      end
    end
  end

  // Watchdog on cycles without a transfer
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_zero_size_and_unknown_owner();
    send_request(vpa_pkg::FUNC_ALLOC, 8'd0, 9'd0);
    send_request(vpa_pkg::FUNC_ALLOC, 8'hFF, 9'd0);
    send_request(vpa_pkg::FUNC_RELEASE, 8'd7, 9'h1FF);
    send_request(vpa_pkg::FUNC_RELEASE, 8'hFF, 9'd0);
  endtask

  task automatic test_extremes();
    send_request(vpa_pkg::FUNC_ALLOC, 8'hFF, 9'd511);
    send_request(vpa_pkg::FUNC_ALLOC, 8'd1, 9'd1);
    send_request(vpa_pkg::FUNC_RELEASE, 8'hFF, 9'd0);
    send_request(vpa_pkg::FUNC_ALLOC, 8'd0, 9'd510);
    send_request(vpa_pkg::FUNC_ALLOC, 8'd1, 9'd1);
    send_request(vpa_pkg::FUNC_ALLOC, 8'd2, 9'd1);
    send_request(vpa_pkg::FUNC_RELEASE, 8'd0, 9'd0);
    send_request(vpa_pkg::FUNC_RELEASE, 8'd1, 9'd0);
    drain();
  endtask

  // Fragment memory so the policies pick different holes
  task automatic test_policies();
    for (int p = 0; p < 4; p++) begin
      write_policy(2'(p));
      send_request(vpa_pkg::FUNC_ALLOC, 8'd10, 9'd40);
      send_request(vpa_pkg::FUNC_ALLOC, 8'd11, 9'd9);
      send_request(vpa_pkg::FUNC_ALLOC, 8'd10, 9'd20);
      send_request(vpa_pkg::FUNC_ALLOC, 8'd11, 9'd9);
      send_request(vpa_pkg::FUNC_RELEASE, 8'd10, 9'd0);
      send_request(vpa_pkg::FUNC_ALLOC, 8'd12, 9'd15);
      send_request(vpa_pkg::FUNC_RELEASE, 8'd11, 9'd0);
      send_request(vpa_pkg::FUNC_RELEASE, 8'd12, 9'd0);
      drain();
    end
  endtask

  // Fill the table with small blocks until the split limit is hit
  task automatic test_table_full();
    write_policy(vpa_pkg::POL_FIRST);
    for (int i = 0; i < MAX_PARTS + 2; i++) send_request(vpa_pkg::FUNC_ALLOC, 8'(i), 9'd1);
    send_request(vpa_pkg::FUNC_ALLOC, 8'd200, 9'd500);
    for (int i = 0; i < MAX_PARTS + 2; i++) send_request(vpa_pkg::FUNC_RELEASE, 8'(i), 9'd0);
    drain();
  endtask

  task automatic test_random();
    int n;
    n = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_policy(phase == 5 ? 2'd3 : 2'($urandom_range(0, 2)));
      for (int i = 0; i < 220; i++) begin
        logic [7:0] owner;
        logic [8:0] size;
        owner = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0: size = 9'($urandom);
          1: size = 9'd0;
          default: size = 9'($urandom_range(1, 40));
        endcase
        send_request($urandom_range(0, 3) == 0 ? vpa_pkg::FUNC_RELEASE : vpa_pkg::FUNC_ALLOC,
                     owner, size);
        n++;
        if (n % 300 == 0) wait_results();
      end
      drain();
    end
  endtask

  initial begin
    table_reset();
    policy = vpa_pkg::POL_FIRST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_zero_size_and_unknown_owner();
    test_extremes();
    test_policies();
    test_table_full();
    test_random();
    drain();
    $display("Covered %0d requests over all fit policies: ok %0d, bad size %0d, no fit %0d,",
             sent, status_seen[0], status_seen[1], status_seen[2]);
    $display("  owner not found %0d, table full %0d; %0d answers compared",
             status_seen[3], status_seen[4], checked);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
